FILE: rtl/core/wbf_pkg.sv
// Package for the word blocklist filter: sizes, beat structs, command codes,
// controller states and the control/status bundles between the two units.
// No dependencies.
package wbf_pkg;

    localparam int MAX_WORD      = 16;
    localparam int TABLE_ENTRIES = 16;

    localparam int WCNT_W  = $clog2(MAX_WORD + 1);
    localparam int WIDX_W  = $clog2(MAX_WORD);
    localparam int ENT_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int BADDR_W = (TABLE_ENTRIES * MAX_WORD > 1) ?
                             $clog2(TABLE_ENTRIES * MAX_WORD) : 1;
    localparam int LEN_W   = 5;

    localparam logic [7:0] UPPER_A = 8'd65;
    localparam logic [7:0] UPPER_Z = 8'd90;
    localparam logic [7:0] LOWER_A = 8'd97;
    localparam logic [7:0] LOWER_Z = 8'd122;

    typedef enum logic [1:0] {
        CMD_MSG     = 2'd0,
        CMD_EOM     = 2'd1,
        CMD_WR_CHAR = 2'd2,
        CMD_SET_LEN = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd             command;
        logic [7:0]       data_byte;
        logic [3:0]       entry_index;
        logic [3:0]       char_position;
        logic [LEN_W-1:0] entry_length;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_out_beat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_M_ENT,
        ST_M_RD,
        ST_M_CMP,
        ST_D_RD,
        ST_D_OUT,
        ST_BYTE
    } t_state;

    typedef struct packed {
        logic take;
        logic ent_inc;
        logic ci_inc;
        logic ci_clr;
        logic cnt_clr;
        logic load_word;
        logic load_byte;
    } t_ctl;

    typedef struct packed {
        logic in_valid;
        logic in_msg;
        logic in_eom;
        logic in_letter;
        logic passing;
        logic cnt_zero;
        logic cnt_full;
        logic len_hit;
        logic ent_last;
        logic ci_last;
        logic chars_eq;
        logic has_byte;
        logic slot_free;
    } t_sts;

    function automatic logic is_letter(input logic [7:0] b);
        return ((b >= UPPER_A) && (b <= UPPER_Z)) || ((b >= LOWER_A) && (b <= LOWER_Z));
    endfunction

endpackage

FILE: rtl/core/word_blocklist_filter_top.sv
// Channel   | dir | handshake                   | payload
// in        | in  | i_in_valid / o_in_stall     | i_in_beat  (wbf_pkg::t_in_beat)
// out       | out | o_out_valid / i_out_stall   | o_out_beat (wbf_pkg::t_out_beat)
// A beat is taken only while the controller is idle. Letters that are buffered and
// blocklist writes keep it idle. A flush skips entries of wrong length, compares
// the others character by character (registered read of both memories, then compare),
// then dumps a kept word character by character; a pending byte goes out last.
// Reset (synchronous, active low) clears the length table, word count, long-word
// flag, controller state and output valid.
// A stall on the output holds the result register; the sequencer waits in its
// emit states until the register frees up.
module word_blocklist_filter_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  wbf_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output wbf_pkg::t_out_beat o_out_beat
);
    import wbf_pkg::*;

    t_ctl w_ctl;
    t_sts w_sts;
    logic w_busy;

    wbf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_ctl   (w_ctl),
        .o_busy  (w_busy)
    );

    wbf_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_beat   (i_in_beat),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_ctl       (w_ctl),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat)
    );

    assign o_in_stall = w_busy;

endmodule

FILE: rtl/core/wbf_datapath.sv
// Datapath of the word filter: word buffer and blocklist memories, length
// table, scan counters, pending byte and the output register.
// Depends on wbf_pkg.
module wbf_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wbf_pkg::t_in_beat i_in_beat,
    input  logic              i_in_valid,
    input  logic              i_out_stall,
    input  wbf_pkg::t_ctl     i_ctl,
    output wbf_pkg::t_sts     o_sts,
    output logic              o_out_valid,
    output wbf_pkg::t_out_beat o_out_beat
);
    import wbf_pkg::*;

    logic [7:0]       r_wmem [MAX_WORD];
    logic [7:0]       r_bmem [TABLE_ENTRIES * MAX_WORD];
    logic [LEN_W-1:0] r_lens [TABLE_ENTRIES];

    logic [WCNT_W-1:0] r_cnt;
    logic              r_passing;
    logic [ENT_W-1:0]  r_ent;
    logic [WIDX_W-1:0] r_ci;
    logic [7:0]        r_byte;
    logic              r_has_byte;
    logic [7:0]        r_wrd;
    logic [7:0]        r_brd;
    logic              r_out_valid;
    t_out_beat         r_out;

    logic              w_letter;
    logic              w_idx_ok;
    logic              w_pos_ok;
    logic [ENT_W-1:0]  w_widx;
    logic [WIDX_W-1:0] w_wpos;
    logic [BADDR_W-1:0] w_bwaddr;
    logic [BADDR_W-1:0] w_braddr;
    logic              w_ci_last;
    logic              w_slot;

    assign w_letter = is_letter(i_in_beat.data_byte);
    assign w_idx_ok = int'(i_in_beat.entry_index) < TABLE_ENTRIES;
    assign w_pos_ok = int'(i_in_beat.char_position) < MAX_WORD;
    assign w_widx   = ENT_W'(i_in_beat.entry_index);
    assign w_wpos   = WIDX_W'(i_in_beat.char_position);
    assign w_bwaddr = BADDR_W'(int'(w_widx) * MAX_WORD + int'(w_wpos));
    assign w_braddr = BADDR_W'(int'(r_ent) * MAX_WORD + int'(r_ci));
    assign w_ci_last = (WCNT_W'(r_ci) + WCNT_W'(1)) == r_cnt;
    assign w_slot   = !r_out_valid || !i_out_stall;

    always_comb begin
        o_sts.in_valid  = i_in_valid;
        o_sts.in_msg    = i_in_beat.command == CMD_MSG;
        o_sts.in_eom    = i_in_beat.command == CMD_EOM;
        o_sts.in_letter = w_letter;
        o_sts.passing   = r_passing;
        o_sts.cnt_zero  = r_cnt == '0;
        o_sts.cnt_full  = int'(r_cnt) == MAX_WORD;
        o_sts.len_hit   = int'(r_lens[r_ent]) == int'(r_cnt);
        o_sts.ent_last  = int'(r_ent) == TABLE_ENTRIES - 1;
        o_sts.ci_last   = w_ci_last;
        o_sts.chars_eq  = r_wrd == r_brd;
        o_sts.has_byte  = r_has_byte;
        o_sts.slot_free = w_slot;
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (i_ctl.take && i_in_beat.command == CMD_MSG && w_letter && !r_passing &&
            int'(r_cnt) < MAX_WORD) begin
            r_wmem[WIDX_W'(r_cnt)] <= i_in_beat.data_byte;
        end
        if (i_ctl.take && i_in_beat.command == CMD_WR_CHAR && w_idx_ok && w_pos_ok) begin
            r_bmem[w_bwaddr] <= i_in_beat.data_byte;
        end
        r_wrd <= r_wmem[r_ci];
        r_brd <= r_bmem[w_braddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_passing   <= 1'b0;
            r_has_byte  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < TABLE_ENTRIES; k++) begin
                r_lens[k] <= '0;
            end
        end else begin
            if (i_ctl.take) begin
                // every message byte except a buffered letter leaves a byte to send
                r_has_byte <= (i_in_beat.command == CMD_MSG) &&
                              !(w_letter && !r_passing && int'(r_cnt) < MAX_WORD);
                unique case (i_in_beat.command)
                    CMD_MSG: begin
                        if (!w_letter) begin
                            r_passing <= 1'b0;
                        end else if (!r_passing) begin
                            if (int'(r_cnt) < MAX_WORD) begin
                                r_cnt <= r_cnt + WCNT_W'(1);
                            end else begin
                                r_passing <= 1'b1;
                            end
                        end
                    end
                    CMD_EOM: begin
                        r_passing <= 1'b0;
                    end
                    CMD_WR_CHAR: begin
                    end
                    CMD_SET_LEN: begin
                        if (w_idx_ok) begin
                            r_lens[w_widx] <= i_in_beat.entry_length;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_ctl.cnt_clr) begin
                r_cnt <= '0;
            end
            if (i_ctl.load_word || i_ctl.load_byte) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.take) begin
            r_byte <= i_in_beat.data_byte;
            r_ent  <= '0;
            r_ci   <= '0;
        end else begin
            if (i_ctl.ent_inc) begin
                r_ent <= r_ent + ENT_W'(1);
                r_ci  <= '0;
            end
            if (i_ctl.ci_clr) begin
                r_ci <= '0;
            end else if (i_ctl.ci_inc) begin
                r_ci <= r_ci + WIDX_W'(1);
            end
        end
        if (i_ctl.load_word) begin
            r_out.out_byte <= r_wrd;
            r_out.last     <= w_ci_last && !r_has_byte;
        end else if (i_ctl.load_byte) begin
            r_out.out_byte <= r_byte;
            r_out.last     <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule

FILE: rtl/core/wbf_ctrl.sv
// Controller of the word filter: sequences input take, blocklist scan,
// word dump and delimiter emission.
// Depends on wbf_pkg.
module wbf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  wbf_pkg::t_sts i_sts,
    output wbf_pkg::t_ctl o_ctl,
    output logic          o_busy
);
    import wbf_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_take;

    assign w_take = (r_state == ST_IDLE) && i_sts.in_valid;
    assign o_busy = r_state != ST_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    if (i_sts.in_msg && i_sts.in_letter) begin
                        if (i_sts.passing) begin
                            n_state = ST_BYTE;
                        end else if (i_sts.cnt_full) begin
                            n_state = ST_D_RD;
                        end
                    end else if (i_sts.in_msg || i_sts.in_eom) begin
                        if (!i_sts.cnt_zero) begin
                            n_state = ST_M_ENT;
                        end else if (i_sts.in_msg) begin
                            n_state = ST_BYTE;
                        end
                    end
                end
            end
            ST_M_ENT: begin
                if (i_sts.len_hit) begin
                    n_state = ST_M_RD;
                end else if (i_sts.ent_last) begin
                    n_state = ST_D_RD;
                end
            end
            ST_M_RD: begin
                n_state = ST_M_CMP;
            end
            ST_M_CMP: begin
                if (i_sts.chars_eq) begin
                    if (i_sts.ci_last) begin
                        n_state = i_sts.has_byte ? ST_BYTE : ST_IDLE;
                    end else begin
                        n_state = ST_M_RD;
                    end
                end else if (i_sts.ent_last) begin
                    n_state = ST_D_RD;
                end else begin
                    n_state = ST_M_ENT;
                end
            end
            ST_D_RD: begin
                n_state = ST_D_OUT;
            end
            ST_D_OUT: begin
                if (i_sts.slot_free) begin
                    if (i_sts.ci_last) begin
                        n_state = i_sts.has_byte ? ST_BYTE : ST_IDLE;
                    end else begin
                        n_state = ST_D_RD;
                    end
                end
            end
            ST_BYTE: begin
                if (i_sts.slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctl = '0;
        o_ctl.take = w_take;
        unique case (r_state)
            ST_IDLE: begin
            end
            ST_M_ENT: begin
                if (!i_sts.len_hit) begin
                    if (i_sts.ent_last) begin
                        o_ctl.ci_clr = 1'b1;
                    end else begin
                        o_ctl.ent_inc = 1'b1;
                    end
                end
            end
            ST_M_RD: begin
            end
            ST_M_CMP: begin
                if (i_sts.chars_eq) begin
                    if (i_sts.ci_last) begin
                        o_ctl.cnt_clr = 1'b1;
                    end else begin
                        o_ctl.ci_inc = 1'b1;
                    end
                end else if (i_sts.ent_last) begin
                    o_ctl.ci_clr = 1'b1;
                end else begin
                    o_ctl.ent_inc = 1'b1;
                end
            end
            ST_D_RD: begin
            end
            ST_D_OUT: begin
                if (i_sts.slot_free) begin
                    o_ctl.load_word = 1'b1;
                    if (i_sts.ci_last) begin
                        o_ctl.cnt_clr = 1'b1;
                    end else begin
                        o_ctl.ci_inc = 1'b1;
                    end
                end
            end
            ST_BYTE: begin
                o_ctl.load_byte = i_sts.slot_free;
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: rtl/core/wbf_checker.sv
// Port-level checker for the word filter, bound to the top level.
// Depends on wbf_pkg and word_blocklist_filter_top.
module wbf_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input wbf_pkg::t_in_beat  i_in_beat,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input wbf_pkg::t_out_beat o_out_beat
);
    import wbf_pkg::*;

    logic w_in_acc;
    assign w_in_acc = i_in_valid && !o_in_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_beat))
        else $error("stalled output beat changed");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_table_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_in_beat.command == CMD_SET_LEN || i_in_beat.command == CMD_WR_CHAR)
        |=> !o_in_stall)
        else $error("blocklist write left the block busy");

    a_delim_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_in_beat.command == CMD_MSG && !is_letter(i_in_beat.data_byte)
        |=> o_in_stall)
        else $error("delimiter produced no work");

endmodule

bind word_blocklist_filter_top wbf_checker u_wbf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_beat   (i_in_beat),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_beat  (o_out_beat)
);

FILE: sim/tb_word_blocklist_filter_top.sv
// Testbench for word_blocklist_filter_top: directed and random byte streams and
// blocklist loads, checked beat by beat against an in-bench filter model.
// Depends on wbf_pkg and word_blocklist_filter_top.
`timescale 1ns / 100ps

module tb_word_blocklist_filter_top;
    import wbf_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 700;
    localparam int HOLD_CYCLES  = 200;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_beat  i_in_beat   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_beat o_out_beat;

    word_blocklist_filter_top dut (.*);

    // filter model state
    logic [7:0]       word_buf [MAX_WORD];
    int               word_cnt;
    bit               long_pass;
    logic [7:0]       blk_chars [TABLE_ENTRIES][MAX_WORD];
    logic [LEN_W-1:0] blk_len [TABLE_ENTRIES];
    t_out_beat        pending_bytes [$];

    // blocklist as loaded by the stimulus side
    logic [7:0]        list_chars [TABLE_ENTRIES][MAX_WORD];
    bit [MAX_WORD-1:0] list_written [TABLE_ENTRIES];
    int                list_len [TABLE_ENTRIES];

    int err_cnt     = 0;
    int items_sent  = 0;
    int idle_cycles = 0;
    int hold_req    = 0;
    bit gaps_on     = 1'b0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic bit is_alpha(input logic [7:0] b);
        return b inside {[UPPER_A:UPPER_Z], [LOWER_A:LOWER_Z]};
    endfunction

    function automatic void emit(input logic [7:0] b);
        t_out_beat r;
        r.out_byte = b;
        r.last     = 1'b0;
        pending_bytes = {pending_bytes, r};
    endfunction

    function automatic bit word_on_list();
        bit same;
        for (int e = 0; e < TABLE_ENTRIES; e++) begin
            if (blk_len[e] != 0 && int'(blk_len[e]) == word_cnt) begin
                same = 1'b1;
                for (int i = 0; i < word_cnt; i++)
                    if (blk_chars[e][i] !== word_buf[i]) same = 1'b0;
                if (same) return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void flush_word();
        if (!long_pass && word_cnt > 0 && !word_on_list())
            for (int i = 0; i < word_cnt; i++) emit(word_buf[i]);
        word_cnt  = 0;
        long_pass = 1'b0;
    endfunction

    function automatic void filter_step(input t_in_beat b);
        int n0;
        n0 = pending_bytes.size();
        case (b.command)
            CMD_MSG: begin
                if (!is_alpha(b.data_byte)) begin
                    flush_word();
                    emit(b.data_byte);
                end else if (long_pass) begin
                    emit(b.data_byte);
                end else if (word_cnt < MAX_WORD) begin
                    word_buf[word_cnt] = b.data_byte;
                    word_cnt++;
                end else begin
                    foreach (word_buf[i]) emit(word_buf[i]);
                    emit(b.data_byte);
                    word_cnt  = 0;
                    long_pass = 1'b1;
                end
            end
            CMD_EOM:     flush_word();
            CMD_WR_CHAR: blk_chars[b.entry_index][b.char_position] = b.data_byte;
            CMD_SET_LEN: blk_len[b.entry_index] = b.entry_length;
            default: ;
        endcase
        if (pending_bytes.size() > n0)
            pending_bytes[pending_bytes.size() - 1].last = 1'b1;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) filter_step(i_in_beat);
    end

    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_bytes.size() == 0) begin
                $error("unexpected out beat: out_byte %0h", o_out_beat.out_byte);
                err_cnt++;
            end else begin
                want = pending_bytes.pop_front();
                if (o_out_beat.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %0h, got %0h", want.out_byte,
                           o_out_beat.out_byte);
                    err_cnt++;
                end
                if (o_out_beat.last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, o_out_beat.last);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // output side: random stall bursts, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_req) @(posedge i_clk);
                hold_req = 0;
                i_out_stall <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_item(input t_in_beat b);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        items_sent++;
        do begin
            @(posedge i_clk);
        end while (o_in_stall !== 1'b0);
    endtask

    function automatic t_in_beat rand_fields();
        t_in_beat b;
        b.command       = CMD_MSG;
        b.data_byte     = 8'($urandom);
        b.entry_index   = 4'($urandom);
        b.char_position = 4'($urandom);
        b.entry_length  = LEN_W'($urandom);
        return b;
    endfunction

    function automatic logic [7:0] rand_letter();
        int k;
        k = $urandom_range(0, 51);
        return (k < 26) ? UPPER_A + 8'(k) : LOWER_A + 8'(k - 26);
    endfunction

    function automatic logic [7:0] rand_delim();
        logic [7:0] b;
        b = 8'($urandom);
        while (is_alpha(b)) b = 8'($urandom);
        return b;
    endfunction

    // a length that would compare against unwritten characters becomes one
    // that can never match
    function automatic logic [LEN_W-1:0] safe_len(input int e, input int want);
        for (int i = 0; i < want && i < MAX_WORD; i++)
            if (!list_written[e][i]) return LEN_W'($urandom_range(MAX_WORD + 1, 2**LEN_W - 1));
        return LEN_W'(want);
    endfunction

    function automatic int pick_entry();
        int hits [$];
        for (int e = 0; e < TABLE_ENTRIES; e++)
            if (list_len[e] >= 1 && list_len[e] <= MAX_WORD) hits = {hits, e};
        return (hits.size() == 0) ? -1 : hits[$urandom_range(0, hits.size() - 1)];
    endfunction

    task automatic send_msg(input logic [7:0] c);
        t_in_beat b;
        b = rand_fields();
        b.data_byte = c;
        send_item(b);
    endtask

    task automatic send_eom();
        t_in_beat b;
        b = rand_fields();
        b.command = CMD_EOM;
        send_item(b);
    endtask

    task automatic put_char(input int e, input int p, input logic [7:0] c);
        t_in_beat b;
        b = rand_fields();
        b.command       = CMD_WR_CHAR;
        b.entry_index   = 4'(e);
        b.char_position = 4'(p);
        b.data_byte     = c;
        list_chars[e][p]   = c;
        list_written[e][p] = 1'b1;
        send_item(b);
    endtask

    task automatic put_len(input int e, input logic [LEN_W-1:0] l);
        t_in_beat b;
        b = rand_fields();
        b.command      = CMD_SET_LEN;
        b.entry_index  = 4'(e);
        b.entry_length = l;
        list_len[e] = int'(l);
        send_item(b);
    endtask

    task automatic load_word(input int e, input int n);
        for (int p = 0; p < n; p++) put_char(e, p, rand_letter());
        put_len(e, LEN_W'(n));
    endtask

    task automatic send_noise();
        t_in_beat b;
        b = rand_fields();
        b.command = t_cmd'($urandom_range(0, 3));
        if (b.command == CMD_WR_CHAR) begin
            list_chars[b.entry_index][b.char_position]   = b.data_byte;
            list_written[b.entry_index][b.char_position] = 1'b1;
        end else if (b.command == CMD_SET_LEN) begin
            b.entry_length = safe_len(b.entry_index, b.entry_length);
            list_len[b.entry_index] = int'(b.entry_length);
        end
        send_item(b);
    endtask

    // mostly whole words (listed, near-miss or free) ended by a delimiter or
    // end of message; some list loads and random beats mixed in
    task automatic run_traffic(input int n_items);
        logic [7:0] w [$];
        int         stop_at;
        int         r;
        int         e;
        int         n;
        int         k;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            r = $urandom_range(0, 99);
            w = {};
            if (r < 8) begin
                e = $urandom_range(0, TABLE_ENTRIES - 1);
                n = ($urandom_range(0, 4) == 0) ? MAX_WORD : $urandom_range(1, 5);
                load_word(e, n);
            end else if (r < 18) begin
                send_noise();
            end else begin
                e = pick_entry();
                if (r < 50 && e >= 0) begin
                    for (int i = 0; i < list_len[e]; i++) w = {w, list_chars[e][i]};
                    if (r < 26) begin
                        k = $urandom_range(0, w.size() - 1);
                        w[k] = w[k] ^ 8'h20;
                    end else if (r < 30) begin
                        w = {w, rand_letter()};
                    end
                end else begin
                    n = (r > 92) ? $urandom_range(MAX_WORD, MAX_WORD + 4) : $urandom_range(1, 6);
                    repeat (n) w = {w, rand_letter()};
                end
                foreach (w[i]) send_msg(w[i]);
                if ($urandom_range(0, 6) == 0)
                    send_eom();
                else
                    send_msg(rand_delim());
            end
        end
    endtask

    task automatic test_empty_and_delims();
        send_eom();
        send_msg(8'h00);
        send_msg(8'hFF);
    endtask

    task automatic test_letter_bounds();
        logic [7:0] bytes [$];
        bytes = {8'd64, 8'd65, 8'd90, 8'd91, 8'd96, 8'd97, 8'd122, 8'd123};
        foreach (bytes[i]) send_msg(bytes[i]);
    endtask

    task automatic test_blocked_word();
        int e;
        e = TABLE_ENTRIES - 1;
        put_char(e, 0, "c");
        put_char(e, 1, "a");
        put_char(e, 2, "t");
        put_len(e, LEN_W'(3));
        send_msg("c");
        send_msg("a");
        send_msg("t");
        send_msg(",");
        send_msg("C");
        send_msg("a");
        send_msg("t");
        send_eom();
        put_len(e, '0);
        put_len(0, LEN_W'(2**LEN_W - 1));
    endtask

    task automatic test_backpressure();
        gaps_on  = 1'b0;
        hold_req = HOLD_CYCLES;
        run_traffic(40);
    endtask

    task automatic test_random();
        gaps_on = 1'b1;
        run_traffic(150);
    endtask

    task automatic test_streaming();
        gaps_on = 1'b0;
        run_traffic(40);
    endtask

    initial begin
        foreach (blk_len[e]) begin
            blk_len[e]      = '0;
            list_len[e]     = 0;
            list_written[e] = '0;
        end
        word_cnt  = 0;
        long_pass = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_and_delims();
        test_letter_bounds();
        test_blocked_word();
        test_backpressure();
        test_random();
        test_streaming();
        i_in_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: word_blocklist_filter_top.f
rtl/core/wbf_pkg.sv
rtl/core/wbf_datapath.sv
rtl/core/wbf_ctrl.sv
rtl/core/word_blocklist_filter_top.sv
rtl/core/wbf_checker.sv
sim/tb_word_blocklist_filter_top.sv
